// ===== sv/psbs_pkg.sv =====
// Package with shared constants, codes and control types for the phase-shifted bin sums block.
`timescale 1ns / 1ps

package psbs_pkg;

	localparam int MAX_BIN       = 32;
	localparam int SAMPLE_BITS   = 24;
	localparam int TOTAL_BITS    = 29;
	localparam int PHASE_BITS    = 5;
	localparam int BIN_BITS      = 6;
	localparam int CFG_ADDR_BITS = 2;
	localparam int CFG_DATA_BITS = 6;

	// Register indexes of the configuration port
	localparam logic [CFG_ADDR_BITS-1:0] REG_BIN_SIZE  = CFG_ADDR_BITS'(0);
	localparam logic [CFG_ADDR_BITS-1:0] REG_KEEP_ENDS = CFG_ADDR_BITS'(1);

	// Kind of sum carried by a result
	typedef enum logic [1:0] {
		PART_FULL  = 2'd0,
		PART_LEAD  = 2'd1,
		PART_TRAIL = 2'd2,
		PART_SHORT = 2'd3
	} part_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UPDATE,
		S_LEAD,
		S_FULL,
		S_TRAIL,
		S_SHORT
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic  capture;
		logic  update;
		logic  inc_seen;
		logic  ptr_lead;
		logic  ptr_trail;
		logic  ptr_next_lead;
		logic  ptr_next_trail;
		logic  load;
		part_t sel;
		logic  close_bin;
		logic  clear;
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic first;
		logic pre_close;
		logic last;
		logic keep;
		logic multi;
		logic lead_last;
		logic trail_last;
		logic out_free;
	} dp_status_t;

endpackage

// ===== sv/psbs_sample_if.sv =====
// Input channel interface: one sample request with its end-of-set mark.
`timescale 1ns / 1ps

interface psbs_sample_if;
	logic                                       valid;
	logic                                       ready;
	logic signed [psbs_pkg::SAMPLE_BITS-1:0]    sample;
	logic                                       final_sample;

	modport source (output valid, output sample, output final_sample, input ready);
	modport sink   (input valid, input sample, input final_sample, output ready);
endinterface

// ===== sv/psbs_result_if.sv =====
// Output channel interface: one tagged bin sum request.
`timescale 1ns / 1ps

interface psbs_result_if;
	logic                                     valid;
	logic                                     ready;
	logic [psbs_pkg::PHASE_BITS-1:0]          phase;
	logic [1:0]                               part;
	logic signed [psbs_pkg::TOTAL_BITS-1:0]   total;
	logic                                     burst_end;
	logic                                     data_end;

	modport source (output valid, output phase, output part, output total,
		output burst_end, output data_end, input ready);
	modport sink   (input valid, input phase, input part, input total,
		input burst_end, input data_end, output ready);
endinterface

// ===== sv/psbs_cfg_if.sv =====
// Configuration write channel interface: register index and write data.
`timescale 1ns / 1ps

interface psbs_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [psbs_pkg::CFG_ADDR_BITS-1:0]    addr;
	logic [psbs_pkg::CFG_DATA_BITS-1:0]    data;

	modport source (output valid, output addr, output data, input ready);
	modport sink   (input valid, input addr, input data, output ready);
endinterface

// ===== sv/psbs_datapath.sv =====
// Datapath: configuration registers, phase sum bank, counters and the result register.
`timescale 1ns / 1ps

module psbs_datapath (
	input  logic                                    clk,
	input  logic                                    arst_n,
	psbs_cfg_if.sink                                cfg,
	input  logic signed [psbs_pkg::SAMPLE_BITS-1:0] in_sample,
	input  logic                                    in_final,
	input  psbs_pkg::dp_cmd_t                       cmd,
	output psbs_pkg::dp_status_t                    status,
	psbs_result_if.source                           results
);

	localparam logic [psbs_pkg::BIN_BITS-1:0] MaxB = psbs_pkg::BIN_BITS'(psbs_pkg::MAX_BIN);

	logic [psbs_pkg::BIN_BITS-1:0]               bin_size_q;
	logic                                        keep_q;
	logic signed [psbs_pkg::SAMPLE_BITS-1:0]     x_q;
	logic                                        last_q;
	logic signed [psbs_pkg::TOTAL_BITS-1:0]      sums_q [psbs_pkg::MAX_BIN];
	logic [psbs_pkg::BIN_BITS-1:0]               seen_q;
	logic [psbs_pkg::PHASE_BITS-1:0]             closing_q;
	logic [psbs_pkg::PHASE_BITS-1:0]             closed_q;
	logic [psbs_pkg::PHASE_BITS-1:0]             ptr_q;

	logic                                        res_valid_q;
	logic [psbs_pkg::PHASE_BITS-1:0]             phase_q;
	psbs_pkg::part_t                             part_q;
	logic signed [psbs_pkg::TOTAL_BITS-1:0]      total_q;
	logic                                        burst_q;
	logic                                        dend_q;

	logic [psbs_pkg::BIN_BITS-1:0]               eb;
	logic                                        first;
	logic                                        cfg_clear;
	logic signed [psbs_pkg::TOTAL_BITS-1:0]      x_ext;
	logic [psbs_pkg::BIN_BITS-1:0]               ptr_w;
	logic [psbs_pkg::BIN_BITS-1:0]               closed_w;
	logic [psbs_pkg::BIN_BITS-1:0]               closed_inc;
	logic [psbs_pkg::BIN_BITS-1:0]               ptr_inc;
	logic [psbs_pkg::PHASE_BITS-1:0]             close_start;
	logic                                        trail_after;
	logic [psbs_pkg::PHASE_BITS-1:0]             nxt_phase;
	logic signed [psbs_pkg::TOTAL_BITS-1:0]      nxt_total;
	logic                                        nxt_burst;

	// Clamp the bin size to its legal range
	always_comb begin
		if (bin_size_q == '0) begin
			eb = psbs_pkg::BIN_BITS'(1);
		end else if (bin_size_q > MaxB) begin
			eb = MaxB;
		end else begin
			eb = bin_size_q;
		end
	end

	assign first       = seen_q < eb;
	assign x_ext       = psbs_pkg::TOTAL_BITS'(x_q);
	assign ptr_w       = {1'b0, ptr_q};
	assign closed_w    = {1'b0, closed_q};
	assign closed_inc  = closed_w + psbs_pkg::BIN_BITS'(1);
	assign ptr_inc     = ptr_w + psbs_pkg::BIN_BITS'(1);
	assign close_start = ({1'b0, closing_q} >= eb) ? '0 : closing_q;
	assign trail_after = last_q && keep_q && (eb > psbs_pkg::BIN_BITS'(1));
	assign cfg_clear   = cfg.valid && cfg.ready && (cfg.addr == psbs_pkg::REG_BIN_SIZE);

	assign cfg.ready = 1'b1;

	// Status toward the controller
	always_comb begin
		status.first      = first;
		status.pre_close  = first && ((seen_q + psbs_pkg::BIN_BITS'(1)) < eb);
		status.last       = last_q;
		status.keep       = keep_q;
		status.multi      = eb > psbs_pkg::BIN_BITS'(1);
		status.lead_last  = ptr_w == (eb - psbs_pkg::BIN_BITS'(1));
		status.trail_last = (ptr_w == (eb - psbs_pkg::BIN_BITS'(1))) ||
			((ptr_w == (eb - psbs_pkg::BIN_BITS'(2))) &&
			(closed_w == (eb - psbs_pkg::BIN_BITS'(1))));
		status.out_free   = !res_valid_q || results.ready;
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_size_q <= psbs_pkg::BIN_BITS'(1);
			keep_q     <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.addr)
				psbs_pkg::REG_BIN_SIZE:  bin_size_q <= cfg.data[psbs_pkg::BIN_BITS-1:0];
				psbs_pkg::REG_KEEP_ENDS: keep_q     <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Capture the accepted sample
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q    <= in_sample;
			last_q <= in_final;
		end
	end

	// Accumulate into every started phase, zero a closed bin, clear at set end or on a bin size write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < psbs_pkg::MAX_BIN; p++) sums_q[p] <= '0;
		end else if (cmd.clear || cfg_clear) begin
			for (int p = 0; p < psbs_pkg::MAX_BIN; p++) sums_q[p] <= '0;
		end else if (cmd.update) begin
			for (int p = 0; p < psbs_pkg::MAX_BIN; p++) begin
				if ((psbs_pkg::BIN_BITS'(p) < eb) &&
					(!first || (psbs_pkg::BIN_BITS'(p) <= seen_q))) begin
					sums_q[p] <= sums_q[p] + x_ext;
				end
			end
		end else if (cmd.close_bin) begin
			sums_q[closed_q] <= '0;
		end
	end

	// Track samples seen and the next phase to close
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= '0;
			closing_q <= '0;
		end else if (cmd.clear || cfg_clear) begin
			seen_q    <= '0;
			closing_q <= '0;
		end else if (cmd.inc_seen) begin
			seen_q <= seen_q + psbs_pkg::BIN_BITS'(1);
		end else if (cmd.close_bin) begin
			seen_q    <= eb;
			closing_q <= (closed_inc == eb) ? '0 : closed_inc[psbs_pkg::PHASE_BITS-1:0];
		end
	end

	// Hold the phase being closed and the burst pointer
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			closed_q <= first ? '0 : close_start;
		end
		if (cmd.ptr_lead) begin
			ptr_q <= psbs_pkg::PHASE_BITS'(1);
		end else if (cmd.ptr_trail) begin
			ptr_q <= (closed_q == '0) ? psbs_pkg::PHASE_BITS'(1) : '0;
		end else if (cmd.ptr_next_lead) begin
			ptr_q <= ptr_inc[psbs_pkg::PHASE_BITS-1:0];
		end else if (cmd.ptr_next_trail) begin
			if (ptr_inc[psbs_pkg::PHASE_BITS-1:0] == closed_q) begin
				ptr_q <= ptr_q + psbs_pkg::PHASE_BITS'(2);
			end else begin
				ptr_q <= ptr_inc[psbs_pkg::PHASE_BITS-1:0];
			end
		end
	end

	// Select the next result
	always_comb begin
		case (cmd.sel)
			psbs_pkg::PART_LEAD: begin
				nxt_phase = ptr_q;
				nxt_total = sums_q[0] - sums_q[ptr_q];
				nxt_burst = 1'b0;
			end
			psbs_pkg::PART_FULL: begin
				nxt_phase = closed_q;
				nxt_total = sums_q[closed_q];
				nxt_burst = !trail_after;
			end
			psbs_pkg::PART_TRAIL: begin
				nxt_phase = ptr_q;
				nxt_total = sums_q[ptr_q];
				nxt_burst = status.trail_last;
			end
			default: begin
				nxt_phase = '0;
				nxt_total = '0;
				nxt_burst = 1'b1;
			end
		endcase
	end

	// Result register: load a new request or drop the taken one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			phase_q <= nxt_phase;
			part_q  <= cmd.sel;
			total_q <= nxt_total;
			burst_q <= nxt_burst;
			dend_q  <= nxt_burst && ((cmd.sel == psbs_pkg::PART_SHORT) || last_q);
		end
	end

	assign results.valid     = res_valid_q;
	assign results.phase     = phase_q;
	assign results.part      = part_q;
	assign results.total     = total_q;
	assign results.burst_end = burst_q;
	assign results.data_end  = dend_q;

endmodule

// ===== sv/psbs_ctrl.sv =====
// Controller: sequences sample accept, sum update and the result burst.
`timescale 1ns / 1ps

module psbs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  psbs_pkg::dp_status_t status,
	output psbs_pkg::dp_cmd_t    cmd
);

	psbs_pkg::state_t state_q;
	psbs_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psbs_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			psbs_pkg::S_IDLE: begin
				if (in_valid) state_nxt = psbs_pkg::S_UPDATE;
			end
			psbs_pkg::S_UPDATE: begin
				if (status.pre_close) begin
					state_nxt = status.last ? psbs_pkg::S_SHORT : psbs_pkg::S_IDLE;
				end else if (status.first && status.keep && status.multi) begin
					state_nxt = psbs_pkg::S_LEAD;
				end else begin
					state_nxt = psbs_pkg::S_FULL;
				end
			end
			psbs_pkg::S_LEAD: begin
				if (status.out_free && status.lead_last) state_nxt = psbs_pkg::S_FULL;
			end
			psbs_pkg::S_FULL: begin
				if (status.out_free) begin
					if (status.last && status.keep && status.multi) begin
						state_nxt = psbs_pkg::S_TRAIL;
					end else begin
						state_nxt = psbs_pkg::S_IDLE;
					end
				end
			end
			psbs_pkg::S_TRAIL: begin
				if (status.out_free && status.trail_last) state_nxt = psbs_pkg::S_IDLE;
			end
			psbs_pkg::S_SHORT: begin
				if (status.out_free) state_nxt = psbs_pkg::S_IDLE;
			end
			default: state_nxt = psbs_pkg::S_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd      = '0;
		cmd.sel  = psbs_pkg::PART_FULL;
		in_ready = 1'b0;
		case (state_q)
			psbs_pkg::S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			psbs_pkg::S_UPDATE: begin
				cmd.update   = 1'b1;
				cmd.inc_seen = status.pre_close && !status.last;
				cmd.ptr_lead = !status.pre_close && status.first && status.keep && status.multi;
			end
			psbs_pkg::S_LEAD: begin
				cmd.sel = psbs_pkg::PART_LEAD;
				if (status.out_free) begin
					cmd.load          = 1'b1;
					cmd.ptr_next_lead = !status.lead_last;
				end
			end
			psbs_pkg::S_FULL: begin
				cmd.sel = psbs_pkg::PART_FULL;
				if (status.out_free) begin
					cmd.load      = 1'b1;
					cmd.close_bin = 1'b1;
					if (status.last) begin
						if (status.keep && status.multi) begin
							cmd.ptr_trail = 1'b1;
						end else begin
							cmd.clear = 1'b1;
						end
					end
				end
			end
			psbs_pkg::S_TRAIL: begin
				cmd.sel = psbs_pkg::PART_TRAIL;
				if (status.out_free) begin
					cmd.load = 1'b1;
					if (status.trail_last) begin
						cmd.clear = 1'b1;
					end else begin
						cmd.ptr_next_trail = 1'b1;
					end
				end
			end
			psbs_pkg::S_SHORT: begin
				cmd.sel = psbs_pkg::PART_SHORT;
				if (status.out_free) begin
					cmd.load  = 1'b1;
					cmd.clear = 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== sv/phase_shifted_bin_sums.sv =====
// Top level of the phase-shifted bin sums block.
//
// Channels: samples takes one signed Q16.8 sample per request, final_sample
// marking the last of a data set; results gives tagged Q21.8 sums (phase,
// part, total, burst_end, data_end); cfg writes bin_size (index 0) and
// keep_ends (index 1) and is always ready; the user must write cfg only
// while the block is idle, which the block itself does not enforce.
// Flow: a sample passes through accept and update; one that closes a bin, or
// ends a set shorter than a bin, then loads its full bin or a short marker,
// plus the extra results of a burst (up to bin_size-1 leading partials on the
// first close and up to bin_size-1 trailing partials on the final sample).
// The controller moves results one per cycle into the single output register
// while it is free, after updating all phase sums together.
// Reset clears all sums and counters, bin_size to 1 and keep_ends to 0.
// A stalled receiver holds the result register; the burst waits, and no new
// sample is accepted until its burst has been loaded.
`timescale 1ns / 1ps

module phase_shifted_bin_sums (
	input  logic           clk,
	input  logic           arst_n,
	psbs_sample_if.sink    samples,
	psbs_result_if.source  results,
	psbs_cfg_if.sink       cfg
);

	psbs_pkg::dp_cmd_t    cmd;
	psbs_pkg::dp_status_t status;
	logic                 in_ready;

	assign samples.ready = in_ready;

	psbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	psbs_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_sample (samples.sample),
		.in_final  (samples.final_sample),
		.cmd       (cmd),
		.status    (status),
		.results   (results)
	);

endmodule

// ===== sv/psbs_checker.sv =====
// Port-level checker for the phase-shifted bin sums block, with its bind.
`timescale 1ns / 1ps

module psbs_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_valid,
	input logic                                   in_ready,
	input logic                                   out_valid,
	input logic                                   out_ready,
	input logic [psbs_pkg::PHASE_BITS-1:0]        phase,
	input logic [1:0]                             part,
	input logic signed [psbs_pkg::TOTAL_BITS-1:0] total,
	input logic                                   burst_end,
	input logic                                   data_end
);

	// Hold a stalled result request
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(phase) && $stable(part) &&
		$stable(total) && $stable(burst_end) && $stable(data_end))
		else $error("stalled result changed");

	// One sample at a time: no accept right after an accept
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample accepted while previous one in update");

	// End of data set closes the burst
	a_dend: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && data_end |-> burst_end)
		else $error("data_end without burst_end");

	// Short data set result is fixed
	a_short: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (part == psbs_pkg::PART_SHORT) |->
		(phase == '0) && (total == '0) && burst_end && data_end)
		else $error("malformed short data set result");

	// A leading partial never ends a burst and never carries phase zero
	a_lead: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (part == psbs_pkg::PART_LEAD) |-> !burst_end && (phase != '0))
		else $error("leading partial ends a burst");

endmodule

bind phase_shifted_bin_sums psbs_checker u_psbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.phase     (results.phase),
	.part      (results.part),
	.total     (results.total),
	.burst_end (results.burst_end),
	.data_end  (results.data_end)
);

// ===== tb/sv/tb_phase_shifted_bin_sums.sv =====
// Testbench for phase_shifted_bin_sums: directed and random data sets checked against a predictor.
`timescale 1ns / 1ps

module tb_phase_shifted_bin_sums;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 5;
	localparam int MAX_WAIT      = 14;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 400;
	localparam int RANDOM_UPTO   = 200;
	localparam int PRESSURE_LEN  = 40;
	localparam int ITEMS_UPTO    = 270;
	localparam int PRINT_CAP     = 50;
	localparam int RUN_LIMIT_NS  = 20_000_000;

	// Index with no register behind it
	localparam logic [psbs_pkg::CFG_ADDR_BITS-1:0] REG_SPARE = psbs_pkg::CFG_ADDR_BITS'(3);

	localparam logic signed [psbs_pkg::SAMPLE_BITS-1:0] SAMPLE_MAX =
		psbs_pkg::SAMPLE_BITS'((1 << (psbs_pkg::SAMPLE_BITS - 1)) - 1);
	localparam logic signed [psbs_pkg::SAMPLE_BITS-1:0] SAMPLE_MIN =
		psbs_pkg::SAMPLE_BITS'(1 << (psbs_pkg::SAMPLE_BITS - 1));
	localparam logic [psbs_pkg::CFG_DATA_BITS-1:0] SIZE_TOP =
		psbs_pkg::CFG_DATA_BITS'((1 << psbs_pkg::CFG_DATA_BITS) - 1);

	typedef struct packed {
		logic [psbs_pkg::PHASE_BITS-1:0] phase;
		psbs_pkg::part_t                 part;
		logic [psbs_pkg::TOTAL_BITS-1:0] total;
		logic                            burst_end;
		logic                            data_end;
	} bin_result_t;

	logic clk = 1'b0;
	logic arst_n;

	psbs_sample_if smp ();
	psbs_result_if res ();
	psbs_cfg_if    cfg_ch ();

	phase_shifted_bin_sums dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (smp),
		.results (res),
		.cfg     (cfg_ch)
	);

	// Predictor state: running sums per phase and the register copy
	logic [psbs_pkg::TOTAL_BITS-1:0] run_sum [psbs_pkg::MAX_BIN];
	int unsigned                     seen;
	int unsigned                     closing;
	logic [psbs_pkg::BIN_BITS-1:0]   bin_reg;
	logic                            keep_reg;

	bin_result_t due_sums [$];

	int  samples_sent = 0;
	int  sums_checked = 0;
	int  sets_closed  = 0;
	int  regs_written = 0;
	int  mismatches   = 0;
	int  hold_ask     = 0;
	bit  steady       = 1'b0;

	always begin
		clk = 1'b1;
		#(CLK_HALF);
		clk = 1'b0;
		#(CLK_HALF);
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_CAP)
			$display("%0t ns mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [psbs_pkg::TOTAL_BITS-1:0] got,
		input logic [psbs_pkg::TOTAL_BITS-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s of result %0d: got %0h, wanted %0h",
				name, sums_checked, got, want));
	endtask

	function automatic int draw_wait();
		if (steady)
			return 0;
		case ($urandom_range(0, 3))
			0, 1: return 0;
			2: return $urandom_range(0, 3);
			default: return $urandom_range(0, MAX_WAIT);
		endcase
	endfunction

	function automatic logic signed [psbs_pkg::SAMPLE_BITS-1:0] rand_value();
		case ($urandom_range(0, 5))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2, 3: return psbs_pkg::SAMPLE_BITS'($urandom_range(0, 600)) -
				psbs_pkg::SAMPLE_BITS'(300);
			default: return psbs_pkg::SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// Bin size as the block uses it: zero acts as one, above the top acts as the top
	function automatic int unsigned eff_bins();
		if (bin_reg == 0)
			return 1;
		if (bin_reg > psbs_pkg::MAX_BIN)
			return psbs_pkg::MAX_BIN;
		return bin_reg;
	endfunction

	function automatic void clear_set_state();
		foreach (run_sum[p])
			run_sum[p] = '0;
		seen = 0;
		closing = 0;
	endfunction

	function automatic bin_result_t mk_sum(input int unsigned ph, input psbs_pkg::part_t kind,
		input logic [psbs_pkg::TOTAL_BITS-1:0] sum);
		bin_result_t r;
		r.phase = psbs_pkg::PHASE_BITS'(ph);
		r.part = kind;
		r.total = sum;
		r.burst_end = 1'b0;
		r.data_end = 1'b0;
		return r;
	endfunction

	// Work out the sums one accepted sample closes and queue them in order
	function automatic void predict_sums(input logic signed [psbs_pkg::SAMPLE_BITS-1:0] value,
		input logic last);
		bin_result_t                     burst [$];
		bin_result_t                     tail;
		int unsigned                     b;
		int unsigned                     c;
		int unsigned                     closed;
		logic [psbs_pkg::TOTAL_BITS-1:0] x;
		b = eff_bins();
		x = psbs_pkg::TOTAL_BITS'(value);
		if (seen < b) begin
			for (int unsigned p = 0; p <= seen; p++)
				run_sum[p] += x;
			if (seen + 1 < b) begin
				// Short set: one marker result, then start over
				if (last) begin
					tail = mk_sum(0, psbs_pkg::PART_SHORT, '0);
					tail.burst_end = 1'b1;
					tail.data_end = 1'b1;
					due_sums = {due_sums, tail};
					sets_closed++;
					clear_set_state();
				end else begin
					seen++;
				end
				return;
			end
			if (keep_reg)
				for (int unsigned p = 1; p < b; p++)
					burst = {burst,
						mk_sum(p, psbs_pkg::PART_LEAD, run_sum[0] - run_sum[p])};
			burst = {burst, mk_sum(0, psbs_pkg::PART_FULL, run_sum[0])};
			run_sum[0] = '0;
			closed = 0;
			closing = 1 % b;
			seen = b;
		end else begin
			c = (closing >= b) ? 0 : closing;
			for (int unsigned p = 0; p < b; p++)
				run_sum[p] += x;
			burst = {burst, mk_sum(c, psbs_pkg::PART_FULL, run_sum[c])};
			run_sum[c] = '0;
			closed = c;
			closing = (c + 1) % b;
		end
		if (last) begin
			if (keep_reg)
				for (int unsigned p = 0; p < b; p++)
					if (p != closed)
						burst = {burst, mk_sum(p, psbs_pkg::PART_TRAIL, run_sum[p])};
			clear_set_state();
			sets_closed++;
		end
		// Mark the end of this burst, and of the set on the last sample
		tail = burst.pop_back();
		tail.burst_end = 1'b1;
		tail.data_end = last;
		burst = {burst, tail};
		foreach (burst[k])
			due_sums = {due_sums, burst[k]};
	endfunction

	// Offer one sample request after a random gap; valid stays up on return
	task automatic send_sample(input logic signed [psbs_pkg::SAMPLE_BITS-1:0] value,
		input logic last);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			smp.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp.valid <= 1'b1;
		smp.sample <= value;
		smp.final_sample <= last;
		@(posedge clk);
		while (!smp.ready)
			@(posedge clk);
		predict_sums(value, last);
		samples_sent++;
	endtask

	// Drop valid, drain all pending sums and let the block go idle
	task automatic settle();
		smp.valid <= 1'b0;
		while (due_sums.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [psbs_pkg::CFG_ADDR_BITS-1:0] idx,
		input logic [psbs_pkg::CFG_DATA_BITS-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		if (idx == psbs_pkg::REG_BIN_SIZE) begin
			bin_reg = psbs_pkg::BIN_BITS'(value);
			clear_set_state();
		end else if (idx == psbs_pkg::REG_KEEP_ENDS) begin
			keep_reg = value[0];
		end
		regs_written++;
	endtask

	task automatic configure(input logic [psbs_pkg::CFG_DATA_BITS-1:0] size_val,
		input logic keep);
		settle();
		write_reg(psbs_pkg::REG_BIN_SIZE, size_val);
		write_reg(psbs_pkg::REG_KEEP_ENDS, psbs_pkg::CFG_DATA_BITS'(keep));
	endtask

	task automatic send_set(input int unsigned len);
		for (int unsigned i = 1; i <= len; i++)
			send_sample(rand_value(), i == len);
	endtask

	// Reset settings: every sample closes its own bin
	task automatic test_single_bins();
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(SAMPLE_MIN, 1'b0);
		send_sample(-psbs_pkg::SAMPLE_BITS'(1), 1'b1);
	endtask

	// Leading, full and trailing sums, and a set whose final sample follows a drain
	task automatic test_keep_ends();
		configure(psbs_pkg::CFG_DATA_BITS'(4), 1'b1);
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(SAMPLE_MIN, 1'b0);
		send_sample(psbs_pkg::SAMPLE_BITS'(1), 1'b0);
		send_sample(-psbs_pkg::SAMPLE_BITS'(1), 1'b0);
		send_sample(psbs_pkg::SAMPLE_BITS'(256), 1'b1);
		repeat (4) send_sample(SAMPLE_MAX, 1'b0);
		settle();
		send_sample(SAMPLE_MIN, 1'b1);
	endtask

	// Sets shorter than one bin, the shortest being a single sample
	task automatic test_short_sets();
		send_sample(SAMPLE_MAX, 1'b1);
		send_sample(SAMPLE_MIN, 1'b0);
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(psbs_pkg::SAMPLE_BITS'(0), 1'b1);
	endtask

	// Bin size zero, an unused index, and an oversized bin size
	task automatic test_register_edges();
		configure('0, 1'b0);
		send_sample(SAMPLE_MIN, 1'b0);
		send_sample(SAMPLE_MAX, 1'b1);
		settle();
		write_reg(REG_SPARE, SIZE_TOP);
		configure(SIZE_TOP, 1'b1);
		send_set(3);
	endtask

	// Bin size written mid-set restarts it; keep_ends written mid-set applies at once
	task automatic test_midset_writes();
		configure(psbs_pkg::CFG_DATA_BITS'(3), 1'b0);
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(SAMPLE_MAX, 1'b0);
		settle();
		write_reg(psbs_pkg::REG_BIN_SIZE, psbs_pkg::CFG_DATA_BITS'(2));
		send_sample(psbs_pkg::SAMPLE_BITS'(5), 1'b0);
		send_sample(SAMPLE_MIN, 1'b0);
		settle();
		write_reg(psbs_pkg::REG_KEEP_ENDS, psbs_pkg::CFG_DATA_BITS'(1));
		send_sample(psbs_pkg::SAMPLE_BITS'(7), 1'b1);
	endtask

	// Random sets under random settings, mostly well formed
	task automatic test_random_sets(input int upto);
		int unsigned                        b;
		int unsigned                        len;
		int unsigned                        split;
		logic [psbs_pkg::CFG_DATA_BITS-1:0] size_val;
		while (samples_sent < upto) begin
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 9))
					0: size_val = '0;
					1: size_val = psbs_pkg::CFG_DATA_BITS'(psbs_pkg::MAX_BIN);
					2: size_val = psbs_pkg::CFG_DATA_BITS'(
						$urandom_range(psbs_pkg::MAX_BIN + 1, SIZE_TOP));
					3, 4, 5: size_val = psbs_pkg::CFG_DATA_BITS'($urandom_range(1, 4));
					default: size_val = psbs_pkg::CFG_DATA_BITS'($urandom_range(5, 12));
				endcase
				configure(size_val, 1'($urandom_range(0, 1)));
			end
			b = eff_bins();
			if (b > 1 && $urandom_range(0, 7) == 0)
				len = $urandom_range(1, b - 1);
			else if (b >= 16)
				len = b + $urandom_range(0, 6);
			else
				len = b + $urandom_range(0, 2 * b + 2);
			split = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len) : 0;
			for (int unsigned i = 1; i <= len; i++) begin
				send_sample(rand_value(), i == len);
				// Flip keep_ends in the middle of the set
				if (i == split && i < len) begin
					settle();
					write_reg(psbs_pkg::REG_KEEP_ENDS, psbs_pkg::CFG_DATA_BITS'(!keep_reg));
				end
			end
		end
	endtask

	// Receiver holds off while the sender keeps offering, so the block backs up
	task automatic test_backpressure();
		configure(psbs_pkg::CFG_DATA_BITS'(8), 1'b1);
		hold_ask = HOLD_CYCLES;
		send_set(PRESSURE_LEN);
	endtask

	// Back-to-back requests on both sides
	task automatic test_steady_stream(input int upto);
		steady = 1'b1;
		test_random_sets(upto);
		steady = 1'b0;
	endtask

	// Take each result request after a random stall and check it
	initial begin : result_sink
		bin_result_t want;
		int          stall;
		res.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_ask > 0) begin
				stall = hold_ask;
				hold_ask = 0;
			end else begin
				stall = draw_wait();
			end
			if (stall > 0) begin
				res.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res.ready <= 1'b1;
			@(posedge clk);
			while (!res.valid)
				@(posedge clk);
			if (due_sums.size() == 0) begin
				report_mismatch($sformatf("unexpected result phase %0d part %0d total %0h",
					res.phase, res.part, res.total));
			end else begin
				want = due_sums.pop_front();
				check_field("phase", psbs_pkg::TOTAL_BITS'(res.phase),
					psbs_pkg::TOTAL_BITS'(want.phase));
				check_field("part", psbs_pkg::TOTAL_BITS'(res.part),
					psbs_pkg::TOTAL_BITS'(want.part));
				check_field("total", res.total, want.total);
				check_field("burst_end", psbs_pkg::TOTAL_BITS'(res.burst_end),
					psbs_pkg::TOTAL_BITS'(want.burst_end));
				check_field("data_end", psbs_pkg::TOTAL_BITS'(res.data_end),
					psbs_pkg::TOTAL_BITS'(want.data_end));
			end
			sums_checked++;
		end
	end

	initial begin : run_tests
		smp.valid <= 1'b0;
		smp.sample <= '0;
		smp.final_sample <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.addr <= psbs_pkg::REG_BIN_SIZE;
		cfg_ch.data <= '0;
		arst_n <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		clear_set_state();
		bin_reg = psbs_pkg::BIN_BITS'(1);
		keep_reg = 1'b0;
		@(posedge clk);

		test_single_bins();
		test_keep_ends();
		test_short_sets();
		test_register_edges();
		test_midset_writes();
		test_random_sets(RANDOM_UPTO);
		test_backpressure();
		test_steady_stream(ITEMS_UPTO);

		// Drain, then leave room for any stray result
		settle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (due_sums.size() != 0)
			report_mismatch($sformatf("%0d sums never arrived", due_sums.size()));

		$display("Run covered %0d samples in %0d data sets, %0d results, %0d register writes.",
			samples_sent, sets_closed, sums_checked, regs_written);
		$display("Bin sizes 0 to %0d, end partials on and off, short sets, a long receiver hold.",
			SIZE_TOP);
		if (mismatches == 0)
			$display("phase_shifted_bin_sums verification clean");
		else
			$display("phase_shifted_bin_sums verification failed");
		$finish;
	end

	// Stop a hung run
	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("phase_shifted_bin_sums verification failed");
		$finish;
	end

endmodule
